// File: rtl/core/svpwm_pkg.sv
// ============================================================================
// svpwm_pkg
// Shared types and constants for the space vector PWM compare generator.
// ============================================================================
package svpwm_pkg;

   localparam int unsigned CMD_W    = 16;
   localparam int unsigned CMP_W    = 16;
   localparam int unsigned TIME_W   = 16;
   localparam int unsigned DUTY_W   = 18;
   localparam int unsigned PROD_W   = 17;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = 2;

   // 4 * duty in Q.14 units: the half-scale bias 2.0 stands for a duty of 0.5
   localparam logic signed [DUTY_W-1:0] DUTY_BIAS = 18'sd32768;
   // one unit of on-time in Q.14
   localparam logic [TIME_W:0] UNIT_Q14 = 17'd16384;
   localparam logic [CMP_W-1:0] PERIOD_RESET = 16'd2500;

   typedef enum logic [2:0] {
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5,
      SECTOR_6 = 3'd6
   } sector_type;

   // sector and active times after classification
   typedef struct packed {
      sector_type          sector;
      logic [TIME_W-1:0]   t1;
      logic [TIME_W-1:0]   t2;
   } active_time_type;

   // biased scaled duties, one per leg, queued between front and back
   typedef struct packed {
      logic signed [DUTY_W-1:0] s_a;
      logic signed [DUTY_W-1:0] s_b;
      logic signed [DUTY_W-1:0] s_c;
      sector_type               sector;
      logic                     over_mod;
   } duty_item_type;

   // scaled compares before saturation
   typedef struct packed {
      logic [PROD_W-1:0] prod_a;
      logic [PROD_W-1:0] prod_b;
      logic [PROD_W-1:0] prod_c;
      sector_type        sector;
      logic              over_mod;
   } scaled_item_type;

endpackage

// File: rtl/core/svpwm_front.sv
// ============================================================================
// svpwm_front
// Two-stage front end: phase differences and sector, then leg duties.
// ============================================================================
module svpwm_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [15:0]      phase_a_cmd,
   input  logic signed [15:0]      phase_b_cmd,
   input  logic signed [15:0]      phase_c_cmd,
   output logic                    out_valid,
   input  logic                    out_ready,
   output svpwm_pkg::duty_item_type out_data
);
   import svpwm_pkg::*;

   logic            s1_vld_ff, s1_vld_in;
   active_time_type s1_data_ff, s1_data_in;
   logic            s2_vld_ff, s2_vld_in;
   duty_item_type   s2_data_ff, s2_data_in;
   logic            s1_adv, s2_adv;

   logic signed [16:0] r, p, q, neg_r, neg_p, neg_q;
   logic signed [DUTY_W-1:0] t1_s, t2_s, sum_s;
   logic signed [DUTY_W-1:0] full_s, t0_s, d_t1_s, d_t2_s;
   logic [TIME_W:0] sum_u;

   assign s2_adv   = !s2_vld_ff || out_ready;
   assign s1_adv   = !s1_vld_ff || s2_adv;
   assign in_ready = s1_adv;

   // stage 1: line differences and sector by sign tests
   always_comb begin
      r     = {phase_a_cmd[15], phase_a_cmd} - {phase_b_cmd[15], phase_b_cmd};
      p     = {phase_b_cmd[15], phase_b_cmd} - {phase_c_cmd[15], phase_c_cmd};
      q     = {phase_a_cmd[15], phase_a_cmd} - {phase_c_cmd[15], phase_c_cmd};
      neg_r = -r;
      neg_p = -p;
      neg_q = -q;
      s1_data_in = '{sector: SECTOR_1, t1: '0, t2: '0};
      if (p >= 17'sd0 && r > 17'sd0) begin
         s1_data_in = '{sector: SECTOR_1, t1: r[15:0], t2: p[15:0]};
      end else if (r <= 17'sd0 && q > 17'sd0) begin
         s1_data_in = '{sector: SECTOR_2, t1: q[15:0], t2: neg_r[15:0]};
      end else if (q <= 17'sd0 && p > 17'sd0) begin
         s1_data_in = '{sector: SECTOR_3, t1: p[15:0], t2: neg_q[15:0]};
      end else if (p <= 17'sd0 && r < 17'sd0) begin
         s1_data_in = '{sector: SECTOR_4, t1: neg_r[15:0], t2: neg_p[15:0]};
      end else if (r >= 17'sd0 && q < 17'sd0) begin
         s1_data_in = '{sector: SECTOR_5, t1: neg_q[15:0], t2: r[15:0]};
      end else if (q >= 17'sd0 && p < 17'sd0) begin
         s1_data_in = '{sector: SECTOR_6, t1: neg_p[15:0], t2: q[15:0]};
      end
   end

   // stage 2: biased duties, s = 4*d in Q.14 (bias 2.0 is d = 0.5)
   always_comb begin
      t1_s   = $signed({2'b00, s1_data_ff.t1});
      t2_s   = $signed({2'b00, s1_data_ff.t2});
      sum_s  = t1_s + t2_s;
      sum_u  = sum_s[TIME_W:0];
      full_s = DUTY_BIAS + sum_s;
      t0_s   = DUTY_BIAS - sum_s;
      d_t1_s = DUTY_BIAS + t1_s - t2_s;
      d_t2_s = DUTY_BIAS + t2_s - t1_s;
      s2_data_in.sector   = s1_data_ff.sector;
      s2_data_in.over_mod = (sum_u > UNIT_Q14);
      case (s1_data_ff.sector)
         SECTOR_1: begin
            s2_data_in.s_a = full_s; s2_data_in.s_b = d_t2_s; s2_data_in.s_c = t0_s;
         end
         SECTOR_2: begin
            s2_data_in.s_a = d_t1_s; s2_data_in.s_b = full_s; s2_data_in.s_c = t0_s;
         end
         SECTOR_3: begin
            s2_data_in.s_a = t0_s; s2_data_in.s_b = full_s; s2_data_in.s_c = d_t2_s;
         end
         SECTOR_4: begin
            s2_data_in.s_a = t0_s; s2_data_in.s_b = d_t1_s; s2_data_in.s_c = full_s;
         end
         SECTOR_5: begin
            s2_data_in.s_a = d_t2_s; s2_data_in.s_b = t0_s; s2_data_in.s_c = full_s;
         end
         default: begin
            s2_data_in.s_a = full_s; s2_data_in.s_b = t0_s; s2_data_in.s_c = d_t1_s;
         end
      endcase
   end

   always_comb begin
      s1_vld_in = s1_adv ? in_valid : s1_vld_ff;
      s2_vld_in = s2_adv ? s1_vld_ff : s2_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_data_ff <= s1_data_in;
      end
      if (s2_adv) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_vld_ff;
   assign out_data  = s2_data_ff;

endmodule

// File: rtl/core/svpwm_queue.sv
// ============================================================================
// svpwm_queue
// Small FIFO that decouples the front end from the back end.
// ============================================================================
module svpwm_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  svpwm_pkg::duty_item_type push_data,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output svpwm_pkg::duty_item_type pop_data
);
   import svpwm_pkg::*;

   duty_item_type        mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]    count;
   logic                 full, empty, push, pop;

   assign count      = wr_ptr_ff - rd_ptr_ff;
   assign empty      = (wr_ptr_ff == rd_ptr_ff);
   assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign push_ready = !full;
   assign pop_valid  = !empty;
   assign push       = push_valid && !full;
   assign pop        = pop_ready && !empty;
   assign pop_data   = mem_ff[rd_ptr_ff[QUEUE_AW-1:0]];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff[QUEUE_AW-1:0]] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count == $past(count) + 1'b1)
      else $error("queue count did not grow on push");
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count == $past(count) - 1'b1)
      else $error("queue count did not shrink on pop");
`endif

endmodule

// File: rtl/core/svpwm_back.sv
// ============================================================================
// svpwm_back
// Two-stage back end: scale duties by the period, then saturate.
// ============================================================================
module svpwm_back #(
   parameter int unsigned COMPARE_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  svpwm_pkg::duty_item_type in_data,
   input  logic [15:0]              pwm_period,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [15:0]              compare_a,
   output logic [15:0]              compare_b,
   output logic [15:0]              compare_c,
   output svpwm_pkg::sector_type    sector_number,
   output logic                     over_modulation
);
   import svpwm_pkg::*;

   localparam logic [CMP_W-1:0] CMP_CAP = (COMPARE_WIDTH >= CMP_W) ? {CMP_W{1'b1}} :
      CMP_W'((64'd1 << COMPARE_WIDTH) - 64'd1);

   logic            b1_vld_ff, b1_vld_in;
   scaled_item_type b1_data_ff, b1_data_in;
   logic            o_vld_ff, o_vld_in;
   logic [CMP_W-1:0] cmp_a_ff, cmp_b_ff, cmp_c_ff;
   logic [CMP_W-1:0] cmp_a_in, cmp_b_in, cmp_c_in;
   sector_type      sector_ff;
   logic            over_ff;
   logic            b1_adv, o_adv;

   function automatic logic [PROD_W-1:0] scale_duty(input logic signed [DUTY_W-1:0] s,
                                                    input logic [CMP_W-1:0] period);
      logic [PROD_W+CMP_W-1:0] prod;
      prod = s[PROD_W-1:0] * period;
      if (s <= $signed(DUTY_W'(0))) begin
         return '0;
      end
      return prod[PROD_W+CMP_W-1:CMP_W];
   endfunction

   function automatic logic [CMP_W-1:0] clamp_cmp(input logic [PROD_W-1:0] prod,
                                                  input logic [CMP_W-1:0] period);
      logic [CMP_W-1:0] lim;
      lim = (period < CMP_CAP) ? period : CMP_CAP;
      if (prod > {1'b0, lim}) begin
         return lim;
      end
      return prod[CMP_W-1:0];
   endfunction

   assign o_adv    = !o_vld_ff || out_ready;
   assign b1_adv   = !b1_vld_ff || o_adv;
   assign in_ready = b1_adv;

   always_comb begin
      b1_data_in.prod_a   = scale_duty(in_data.s_a, pwm_period);
      b1_data_in.prod_b   = scale_duty(in_data.s_b, pwm_period);
      b1_data_in.prod_c   = scale_duty(in_data.s_c, pwm_period);
      b1_data_in.sector   = in_data.sector;
      b1_data_in.over_mod = in_data.over_mod;
      cmp_a_in = clamp_cmp(b1_data_ff.prod_a, pwm_period);
      cmp_b_in = clamp_cmp(b1_data_ff.prod_b, pwm_period);
      cmp_c_in = clamp_cmp(b1_data_ff.prod_c, pwm_period);
      b1_vld_in = b1_adv ? in_valid : b1_vld_ff;
      o_vld_in  = o_adv ? b1_vld_ff : o_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff <= 1'b0;
         o_vld_ff  <= 1'b0;
      end else begin
         b1_vld_ff <= b1_vld_in;
         o_vld_ff  <= o_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b1_adv) begin
         b1_data_ff <= b1_data_in;
      end
      if (o_adv) begin
         cmp_a_ff  <= cmp_a_in;
         cmp_b_ff  <= cmp_b_in;
         cmp_c_ff  <= cmp_c_in;
         sector_ff <= b1_data_ff.sector;
         over_ff   <= b1_data_ff.over_mod;
      end
   end

   assign out_valid       = o_vld_ff;
   assign compare_a       = cmp_a_ff;
   assign compare_b       = cmp_b_ff;
   assign compare_c       = cmp_c_ff;
   assign sector_number   = sector_ff;
   assign over_modulation = over_ff;

endmodule

// File: rtl/core/space_vector_pwm_compare.sv
// ============================================================================
// space_vector_pwm_compare
// Space vector PWM: phase commands in, three leg compare values out.
// ============================================================================
// Usage:
//   req_*  : one item is three signed Q2.14 phase voltage commands.
//   rsp_*  : one item per request: three compare counts, the 60-degree
//            sector (1..6) and an overmodulation flag (zero time < 0).
//   csr_*  : write port for the PWM period in timer counts; write it only
//            while no item is in flight. It is always ready.
// Timing:
//   One item per cycle is sustained while rsp_tready is high. The front
//   end (sector, duty pattern) feeds a 4-entry queue; the back end
//   (period multiply, saturation) drains it into the output register.
// Stalls and reset:
//   When rsp_tready is low the output holds, the back end halts and the
//   queue fills; req_tready drops only once the queue and the front end
//   stages are all occupied. Reset empties every stage and the queue and
//   loads the period with 2500 counts.
// ============================================================================
module space_vector_pwm_compare #(
   parameter int unsigned COMPARE_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request: [15:0] phase_a_cmd, [31:16] phase_b_cmd, [47:32] phase_c_cmd
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // response: [15:0] compare_a, [31:16] compare_b, [47:32] compare_c,
   //           [50:48] sector_number, [51] over_modulation, [55:52] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   // period register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);
   import svpwm_pkg::*;

   logic [CMP_W-1:0] period_ff, period_in;

   logic          fq_valid, fq_ready;
   duty_item_type fq_data;
   logic          qb_valid, qb_ready;
   duty_item_type qb_data;

   logic [CMP_W-1:0] compare_a, compare_b, compare_c;
   sector_type       sector_number;
   logic             over_modulation;

   // period register: written straight from the port, never back-pressured
   assign csr_ready = 1'b1;
   assign period_in = (csr_valid && csr_ready) ? csr_wdata : period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else begin
         period_ff <= period_in;
      end
   end

   // front end: classify sector and build leg duties
   svpwm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .phase_a_cmd ($signed(req_tdata[15:0])),
      .phase_b_cmd ($signed(req_tdata[31:16])),
      .phase_c_cmd ($signed(req_tdata[47:32])),
      .out_valid   (fq_valid),
      .out_ready   (fq_ready),
      .out_data    (fq_data)
   );

   // queue between the two halves
   svpwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   // back end: scale by period and saturate
   svpwm_back #(
      .COMPARE_WIDTH (COMPARE_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (qb_valid),
      .in_ready        (qb_ready),
      .in_data         (qb_data),
      .pwm_period      (period_ff),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .compare_a       (compare_a),
      .compare_b       (compare_b),
      .compare_c       (compare_c),
      .sector_number   (sector_number),
      .over_modulation (over_modulation)
   );

   assign rsp_tdata = {4'b0000, over_modulation, sector_number,
                       compare_c, compare_b, compare_a};

`ifndef SYNTHESIS
   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[50:48] != 3'd0 && rsp_tdata[50:48] != 3'd7)
      else $error("sector out of range");
   a_cmp_le_period: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] <= period_ff && rsp_tdata[31:16] <= period_ff &&
                     rsp_tdata[47:32] <= period_ff)
      else $error("compare above period");
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:52] == 4'b0000)
      else $error("response padding not zero");
`endif

endmodule
